// ===== src/md5_pkg.sv =====
// Shared types, constants and round functions of the MD5 digest core.
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    typedef struct packed {
        logic       absorb;
        logic       pad_start;
        logic       pad_wr;
        logic       pad_first;
        logic       pad_final;
        logic       load;
        logic       round_en;
        logic [5:0] round;
        logic [5:0] rd_round;
        logic       add;
        logic       init;
    } t_cmd;

    typedef struct packed {
        logic pos_last;
        logic pos_lt56;
        logic ptr_last;
    } t_status;

    function automatic logic [31:0] f_round_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] f_rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            case ({r[5:4], r[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // Message word index used by round r.
    function automatic logic [3:0] f_word_index(input logic [5:0] r);
        logic [3:0] g;
        logic [3:0] rl;
        begin
            rl = r[3:0];
            case (r[5:4])
                2'd0: g = rl;
                2'd1: g = 4'((rl << 2) + rl + 4'd1);
                2'd2: g = 4'((rl << 1) + rl + 4'd5);
                default: g = 4'((rl << 3) - rl);
            endcase
            return g;
        end
    endfunction

endpackage

// ===== src/md5_dp.sv =====
// Datapath of the MD5 core: block store, chaining words, round unit, length counter.
module md5_dp
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    input  logic        i_sel_hi,
    output t_status     o_status,
    output logic [63:0] o_digest
);

    logic [31:0] r_mem [16];
    logic [31:0] r_w;
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [60:0] r_bytes;
    logic [60:0] r_len;
    logic [5:0]  r_ptr;

    logic [5:0]  pos;
    logic [5:0]  wr_pos;
    logic [7:0]  wr_byte;
    logic [7:0]  pad_byte;
    logic [63:0] len_bits;
    logic [31:0] f, t1, rot, k;
    logic [4:0]  s;

    assign pos      = r_bytes[5:0];
    assign len_bits = {r_len, 3'b000};

    always_comb begin
        if (i_cmd.pad_first) begin
            pad_byte = PAD_MARK;
        end else if (i_cmd.pad_final && r_ptr >= LEN_POS) begin
            pad_byte = len_bits[{r_ptr[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
        wr_pos  = i_cmd.absorb ? pos : r_ptr;
        wr_byte = i_cmd.absorb ? i_byte : pad_byte;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb || i_cmd.pad_wr) begin
            r_mem[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
        end
        r_w <= r_mem[f_word_index(i_cmd.rd_round)];
    end

    always_comb begin
        case (i_cmd.round[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        k   = f_round_const(i_cmd.round);
        s   = f_rot_amount(i_cmd.round);
        t1  = r_a + f + k + r_w;
        rot = (t1 << s) | (t1 >> (6'd32 - {1'b0, s}));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
        end else if (i_cmd.round_en) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
        if (i_cmd.pad_start) begin
            r_len <= r_bytes;
            r_ptr <= pos;
        end else if (i_cmd.pad_wr) begin
            r_ptr <= r_ptr + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_h[0]  <= INIT_A;
            r_h[1]  <= INIT_B;
            r_h[2]  <= INIT_C;
            r_h[3]  <= INIT_D;
            r_bytes <= '0;
        end else begin
            if (i_cmd.add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
            end
            if (i_cmd.absorb) begin
                r_bytes <= r_bytes + 61'd1;
            end
        end
    end

    assign o_status.pos_last = (pos == 6'd63);
    assign o_status.pos_lt56 = (pos < LEN_POS);
    assign o_status.ptr_last = (r_ptr == 6'd63);
    assign o_digest = i_sel_hi ? {r_h[3], r_h[2]} : {r_h[1], r_h[0]};

endmodule

// ===== src/md5_ctrl.sv =====
// Controller of the MD5 core: request handshakes, padding sequence and round counter.
module md5_ctrl
    import md5_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_finish,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output logic    o_out_last,
    output logic    o_sel_hi,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT0  = 3'd5;
    localparam logic [2:0] S_OUT1  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [5:0] r_round, n_round;
    logic       r_final, n_final;
    logic       r_first, n_first;
    logic       r_fin, n_fin;
    logic       in_acc;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_final = r_final;
        n_first = r_first;
        n_fin   = r_fin;
        o_cmd   = '0;
        o_cmd.round     = r_round;
        o_cmd.pad_first = r_first;
        o_cmd.pad_final = r_final;
        o_cmd.rd_round  = r_round + 6'd1;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        o_sel_hi    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    if (i_in_finish) begin
                        o_cmd.pad_start = 1'b1;
                        n_final = i_status.pos_lt56;
                        n_first = 1'b1;
                        n_state = S_PAD;
                    end else begin
                        o_cmd.absorb = 1'b1;
                        if (i_status.pos_last) begin
                            n_fin   = 1'b0;
                            n_state = S_PREP;
                        end
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad_wr = 1'b1;
                n_first = 1'b0;
                if (i_status.ptr_last) begin
                    n_fin   = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.load     = 1'b1;
                o_cmd.rd_round = 6'd0;
                n_round = 6'd0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_final) begin
                    n_state = S_OUT0;
                end else begin
                    // The marker did not leave room for the length: pad a second block.
                    n_final = 1'b1;
                    n_state = S_PAD;
                end
            end
            S_OUT0: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_OUT1;
                end
            end
            S_OUT1: begin
                o_out_valid = 1'b1;
                o_out_last  = 1'b1;
                o_sel_hi    = 1'b1;
                if (i_out_ready) begin
                    o_cmd.init = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_final <= 1'b0;
            r_first <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_final <= n_final;
            r_first <= n_first;
            r_fin   <= n_fin;
        end
    end

    a_out_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT0 && $past(r_state) != S_OUT0) |-> $past(r_state) == S_ADD)
        else $error("digest presented without a finished compression");

    a_round_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && $past(r_state) == S_ROUND) |->
        r_round == $past(r_round) + 6'd1)
        else $error("round counter skipped");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("request taken while digest pending");

    a_pad_final_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && r_fin && !r_final) |=> r_state == S_PAD)
        else $error("extra pad block not started");

endmodule

// ===== src/md5_message_digest_core.sv =====
// Top level of the MD5 digest core: stream ports around controller and datapath.
// Each absorb request writes one message byte into the block store; every 64th byte
// starts a compression (load, 64 rounds at one round per cycle through a single round
// unit, chaining add), during which no request is taken. A finish request writes the
// padding one byte per cycle from the current position to the block end, runs one or
// two compressions, then presents the digest as two 64-bit halves, low bytes first,
// with tlast on the second; after that the core is back at the initial state.
module md5_message_digest_core
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_half
    output logic        m_tlast
);

    t_cmd    cmd;
    t_status status;
    logic    sel_hi;

    md5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .i_in_finish (s_tuser),
        .i_out_ready (m_tready),
        .i_status    (status),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .o_out_last  (m_tlast),
        .o_sel_hi    (sel_hi),
        .o_cmd       (cmd)
    );

    md5_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (s_tdata),
        .i_sel_hi (sel_hi),
        .o_status (status),
        .o_digest (m_tdata)
    );

endmodule
